### rtl/assert_macros.svh
// Assertion macros used by the rate limited FIFO RTL.
// No dependencies; clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SWRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define SWRL_ASSERT_NEVER(lbl, cond, msg) \
  `SWRL_ASSERT(lbl, !(cond), msg)

`endif

### rtl/swrl_pkg.sv
// Shared types, codes and helpers of the sliding window rate limited FIFO.
// No dependencies.
package swrl_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 64;
  localparam int unsigned LOG_DEPTH_DEF  = 64;

  localparam logic [21:0] BYTE_MAX  = 22'h3FFFFF;
  localparam logic [31:0] TALLY_MAX = 32'hFFFFFFFF;

  localparam logic [31:0] WINDOW_RST = 32'd1000;
  localparam logic [6:0]  RATE_RST   = 7'd10;
  localparam logic [6:0]  BUF_RST    = 7'd64;

  typedef enum logic [1:0] {
    CMD_ARRIVE  = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_RATE_REJ = 3'd1,
    ST_FULL_REJ = 3'd2,
    ST_DEQUEUED = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_WINDOW = 2'd0,
    CFG_RATE   = 2'd1,
    CFG_BUFFER = 2'd2
  } cfg_idx_e;

  // Saturating increment of a statistics counter.
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == TALLY_MAX) ? v : v + 32'd1;
  endfunction

endpackage

### rtl/swrl_ram.sv
// Simple dual port synchronous RAM, one write and one registered read port.
// No dependencies; used for the packet store and the time log.
module swrl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sliding_window_rate_limited_fifo_unit.sv
// Top level: sliding window log rate limiter in front of a bounded receive FIFO.
// Depends on swrl_pkg, swrl_ram and assert_macros.svh.
//
//   channel   direction  handshake               payload
//   request   in         in_valid_i/in_ready_o   cmd_i, arrival_time_i, packet_size_i
//   result    out        out_valid_o/out_ready_i status_o, out_time_o, out_size_o, stats
//   config    in         cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// Arrival: the request is registered, then S_PURGE drops expired log entries;
// the time log read port checks one entry per cycle. Dequeue of a held packet:
// registered packet store read, then S_DEQ. Clear, empty dequeue: answered in
// S_IDLE. Reset takes effect at once, no memory sweep. A request is taken only
// when the result register is free or being emptied in the same cycle;
// statistics outputs show the state left by the last request.
module sliding_window_rate_limited_fifo_unit #(
  parameter int unsigned FIFO_DEPTH = swrl_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned LOG_DEPTH  = swrl_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [47:0] arrival_time_i,
  input  logic [15:0] packet_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [47:0] out_time_o,
  output logic [15:0] out_size_o,
  output logic [21:0] bytes_in_use_o,
  output logic [6:0]  packets_in_use_o,
  output logic [31:0] accepted_count_o,
  output logic [31:0] rate_reject_count_o,
  output logic [31:0] full_reject_count_o,
  output logic [21:0] peak_bytes_o,
  output logic [6:0]  peak_packets_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned AWF  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned AWL  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CWF  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CWL  = $clog2(LOG_DEPTH + 1);
  localparam int unsigned CWM  = (CWF > CWL) ? CWF : CWL;
  localparam int unsigned CMPW = (CWM > 7) ? CWM : 7;
  localparam int unsigned SWF  = CWF + 1;
  localparam int unsigned SWL  = CWL + 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PURGE = 3'b010,
    S_DEQ   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [31:0] window_q;
  logic [6:0]  rate_lim_q, buf_lim_q;

  logic [AWF-1:0] fifo_head_q, fifo_head_d;
  logic [CWF-1:0] fifo_count_q, fifo_count_d;
  logic [AWL-1:0] log_head_q, log_head_d;
  logic [CWL-1:0] log_count_q, log_count_d;
  logic [21:0]    byte_total_q, byte_total_d;
  logic [31:0]    accept_q, accept_d;
  logic [31:0]    rate_drop_q, rate_drop_d;
  logic [31:0]    full_drop_q, full_drop_d;
  logic [21:0]    byte_peak_q, byte_peak_d;
  logic [CWF-1:0] count_peak_q, count_peak_d;

  logic [47:0] now_q, now_d;
  logic [15:0] size_q, size_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q, status_d;
  logic [47:0] out_time_q, out_time_d;
  logic [15:0] out_size_q, out_size_d;

  // Memory ports
  logic           pkt_we;
  logic [AWF-1:0] pkt_waddr;
  logic [63:0]    pkt_rdata;
  logic           log_we;
  logic [AWL-1:0] log_waddr, log_raddr;
  logic [47:0]    log_rdata;

  logic in_fire;

  // Working values of the arrival decision
  logic [AWL-1:0]  log_head_inc;
  logic [AWF-1:0]  fifo_head_inc;
  logic [47:0]     age;
  logic            expired;
  logic [CMPW-1:0] rate_ext, buf_ext, lim, cap;
  logic [SWF-1:0]  fifo_tail_sum;
  logic [SWL-1:0]  log_tail_sum;
  logic [22:0]     byte_sum;
  logic [21:0]     byte_new;
  logic [CWF-1:0]  fifo_count_inc;
  logic [15:0]     deq_size;

  swrl_ram #(.WIDTH(64), .DEPTH(FIFO_DEPTH)) u_pkt_store (
    .clk_i   (clk_i),
    .we_i    (pkt_we),
    .waddr_i (pkt_waddr),
    .wdata_i ({now_q, size_q}),
    .raddr_i (fifo_head_q),
    .rdata_o (pkt_rdata)
  );

  swrl_ram #(.WIDTH(48), .DEPTH(LOG_DEPTH)) u_time_log (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (log_waddr),
    .wdata_i (now_q),
    .raddr_i (log_raddr),
    .rdata_o (log_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // Head advance with wrap
  assign log_head_inc  = (log_head_q == AWL'(LOG_DEPTH - 1)) ? '0 : log_head_q + AWL'(1);
  assign fifo_head_inc = (fifo_head_q == AWF'(FIFO_DEPTH - 1)) ? '0 : fifo_head_q + AWF'(1);

  // Expiry test on the oldest logged time
  assign age     = now_q - log_rdata;
  assign expired = (log_count_q != '0) && (now_q > log_rdata) && (age > {16'd0, window_q});

  // Effective limits, bounded by the memory depths
  assign rate_ext = CMPW'(rate_lim_q);
  assign buf_ext  = CMPW'(buf_lim_q);
  assign lim      = (rate_ext < CMPW'(LOG_DEPTH)) ? rate_ext : CMPW'(LOG_DEPTH);
  assign cap      = (buf_ext < CMPW'(FIFO_DEPTH)) ? buf_ext : CMPW'(FIFO_DEPTH);

  // Tail addresses: head plus count, one wrap at most
  always_comb begin
    fifo_tail_sum = SWF'(fifo_head_q) + SWF'(fifo_count_q);
    if (fifo_tail_sum >= SWF'(FIFO_DEPTH)) begin
      fifo_tail_sum = fifo_tail_sum - SWF'(FIFO_DEPTH);
    end
    log_tail_sum = SWL'(log_head_q) + SWL'(log_count_q);
    if (log_tail_sum >= SWL'(LOG_DEPTH)) begin
      log_tail_sum = log_tail_sum - SWL'(LOG_DEPTH);
    end
  end

  assign pkt_waddr      = fifo_tail_sum[AWF-1:0];
  assign log_waddr      = log_tail_sum[AWL-1:0];
  assign byte_sum       = {1'b0, byte_total_q} + {7'd0, size_q};
  assign byte_new       = (byte_sum > {1'b0, swrl_pkg::BYTE_MAX}) ? swrl_pkg::BYTE_MAX
                                                                  : byte_sum[21:0];
  assign fifo_count_inc = fifo_count_q + CWF'(1);
  assign deq_size       = pkt_rdata[15:0];

  // Request sequencing and state update
  always_comb begin
    state_d      = state_q;
    fifo_head_d  = fifo_head_q;
    fifo_count_d = fifo_count_q;
    log_head_d   = log_head_q;
    log_count_d  = log_count_q;
    byte_total_d = byte_total_q;
    accept_d     = accept_q;
    rate_drop_d  = rate_drop_q;
    full_drop_d  = full_drop_q;
    byte_peak_d  = byte_peak_q;
    count_peak_d = count_peak_q;
    now_d        = now_q;
    size_d       = size_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    out_time_d   = out_time_q;
    out_size_d   = out_size_q;
    pkt_we       = 1'b0;
    log_we       = 1'b0;
    log_raddr    = log_head_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (swrl_pkg::cmd_e'(cmd_i))
            swrl_pkg::CMD_ARRIVE: begin
              now_d   = arrival_time_i;
              size_d  = packet_size_i;
              state_d = S_PURGE;
            end
            swrl_pkg::CMD_DEQUEUE: begin
              if (fifo_count_q == '0) begin
                out_valid_d = 1'b1;
                status_d    = swrl_pkg::ST_EMPTY;
                out_time_d  = '0;
                out_size_d  = '0;
              end else begin
                state_d = S_DEQ;
              end
            end
            swrl_pkg::CMD_CLEAR: begin
              fifo_head_d  = '0;
              fifo_count_d = '0;
              log_head_d   = '0;
              log_count_d  = '0;
              byte_total_d = '0;
              accept_d     = '0;
              rate_drop_d  = '0;
              full_drop_d  = '0;
              byte_peak_d  = '0;
              out_valid_d  = 1'b1;
              status_d     = swrl_pkg::ST_CLEARED;
              out_time_d   = '0;
              out_size_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_PURGE: begin
        if (expired) begin
          // Drop the oldest entry and fetch the next one
          log_head_d  = log_head_inc;
          log_count_d = log_count_q - CWL'(1);
          log_raddr   = log_head_inc;
        end else begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_time_d  = '0;
          out_size_d  = '0;
          if (CMPW'(log_count_q) >= lim) begin
            status_d    = swrl_pkg::ST_RATE_REJ;
            rate_drop_d = swrl_pkg::sat_inc(rate_drop_q);
          end else if (CMPW'(fifo_count_q) >= cap) begin
            status_d    = swrl_pkg::ST_FULL_REJ;
            full_drop_d = swrl_pkg::sat_inc(full_drop_q);
          end else begin
            status_d     = swrl_pkg::ST_ACCEPTED;
            pkt_we       = 1'b1;
            log_we       = 1'b1;
            fifo_count_d = fifo_count_inc;
            log_count_d  = log_count_q + CWL'(1);
            byte_total_d = byte_new;
            if (byte_new > byte_peak_q) begin
              byte_peak_d = byte_new;
            end
            if (fifo_count_inc > count_peak_q) begin
              count_peak_d = fifo_count_inc;
            end
            accept_d = swrl_pkg::sat_inc(accept_q);
          end
        end
      end

      S_DEQ: begin
        // Pop the head packet read in the previous cycle
        state_d      = S_IDLE;
        out_valid_d  = 1'b1;
        status_d     = swrl_pkg::ST_DEQUEUED;
        out_time_d   = pkt_rdata[63:16];
        out_size_d   = deq_size;
        fifo_head_d  = fifo_head_inc;
        fifo_count_d = fifo_count_q - CWF'(1);
        byte_total_d = (byte_total_q > {6'd0, deq_size}) ? byte_total_q - {6'd0, deq_size}
                                                          : '0;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fifo_head_q  <= '0;
      fifo_count_q <= '0;
      log_head_q   <= '0;
      log_count_q  <= '0;
      byte_total_q <= '0;
      accept_q     <= '0;
      rate_drop_q  <= '0;
      full_drop_q  <= '0;
      byte_peak_q  <= '0;
      count_peak_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fifo_head_q  <= fifo_head_d;
      fifo_count_q <= fifo_count_d;
      log_head_q   <= log_head_d;
      log_count_q  <= log_count_d;
      byte_total_q <= byte_total_d;
      accept_q     <= accept_d;
      rate_drop_q  <= rate_drop_d;
      full_drop_q  <= full_drop_d;
      byte_peak_q  <= byte_peak_d;
      count_peak_q <= count_peak_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    size_q     <= size_d;
    status_q   <= status_d;
    out_time_q <= out_time_d;
    out_size_q <= out_size_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= swrl_pkg::WINDOW_RST;
      rate_lim_q <= swrl_pkg::RATE_RST;
      buf_lim_q  <= swrl_pkg::BUF_RST;
    end else if (cfg_we_i) begin
      case (swrl_pkg::cfg_idx_e'(cfg_idx_i))
        swrl_pkg::CFG_WINDOW: window_q   <= cfg_data_i;
        swrl_pkg::CFG_RATE:   rate_lim_q <= cfg_data_i[6:0];
        swrl_pkg::CFG_BUFFER: buf_lim_q  <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign out_time_o          = out_time_q;
  assign out_size_o          = out_size_q;
  assign bytes_in_use_o      = byte_total_q;
  assign packets_in_use_o    = 7'(fifo_count_q);
  assign accepted_count_o    = accept_q;
  assign rate_reject_count_o = rate_drop_q;
  assign full_reject_count_o = full_drop_q;
  assign peak_bytes_o        = byte_peak_q;
  assign peak_packets_o      = 7'(count_peak_q);

  // Assertions
  `SWRL_ASSERT(a_counts_bounded,
    (fifo_count_q <= CWF'(FIFO_DEPTH)) && (log_count_q <= CWL'(LOG_DEPTH)),
    "queue count beyond its depth")
  `SWRL_ASSERT_NEVER(a_busy_with_result, (state_q != S_IDLE) && out_valid_q,
    "request in flight while a result is pending")
  `SWRL_ASSERT(a_accept_grows,
    $rose(out_valid_q) && (status_q == swrl_pkg::ST_ACCEPTED) |->
    (fifo_count_q == $past(fifo_count_q) + CWF'(1)) &&
    (log_count_q != '0),
    "accepted packet did not grow the queues")

endmodule

### sim/tb_sliding_window_rate_limited_fifo_unit.sv
// Testbench for the sliding window rate limited FIFO gate: random and directed requests,
// with a transaction-level gate predictor and an in-order result checker.
// Depends on swrl_pkg and the sliding_window_rate_limited_fifo_unit RTL.
module tb_sliding_window_rate_limited_fifo_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_CYC   = 80;
  localparam int unsigned DRAIN_CYC    = 100;
  localparam int unsigned HOLD_OFF_CYC = 300;
  localparam int unsigned GATE_DEPTH   = swrl_pkg::FIFO_DEPTH_DEF;
  localparam int unsigned TRAIL_DEPTH  = swrl_pkg::LOG_DEPTH_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] out_time;
    logic [15:0] out_size;
    logic [21:0] bytes_in_use;
    logic [6:0]  packets_in_use;
    logic [31:0] accepted;
    logic [31:0] rate_rejects;
    logic [31:0] full_rejects;
    logic [21:0] peak_bytes;
    logic [6:0]  peak_packets;
  } gate_result_t;

  // DUT connections, inputs driven from time zero
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i          = swrl_pkg::CMD_NONE;
  logic [47:0] arrival_time_i = '0;
  logic [15:0] packet_size_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [2:0]  status_o;
  logic [47:0] out_time_o;
  logic [15:0] out_size_o;
  logic [21:0] bytes_in_use_o;
  logic [6:0]  packets_in_use_o;
  logic [31:0] accepted_count_o;
  logic [31:0] rate_reject_count_o;
  logic [31:0] full_reject_count_o;
  logic [21:0] peak_bytes_o;
  logic [6:0]  peak_packets_o;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_idx_i      = swrl_pkg::CFG_WINDOW;
  logic [31:0] cfg_data_i     = '0;

  // Predictor state: held packets, accept time trail, tallies and register shadows
  logic [47:0]  held_time [GATE_DEPTH];
  logic [15:0]  held_size [GATE_DEPTH];
  int unsigned  held_head  = 0;
  int unsigned  held_count = 0;
  logic [47:0]  accept_trail [TRAIL_DEPTH];
  int unsigned  trail_rd   = 0;
  int unsigned  trail_fill = 0;
  int unsigned  bytes_held = 0;
  int unsigned  byte_high  = 0;
  int unsigned  pkt_high   = 0;
  logic [31:0]  accepts    = '0;
  logic [31:0]  rate_drops = '0;
  logic [31:0]  full_drops = '0;
  logic [31:0]  cfg_window = swrl_pkg::WINDOW_RST;
  logic [6:0]   cfg_rate   = swrl_pkg::RATE_RST;
  logic [6:0]   cfg_buffer = swrl_pkg::BUF_RST;

  gate_result_t gate_results_q[$];
  int unsigned  bad_results   = 0;
  int unsigned  cycle_count   = 0;
  bit           tx_steady     = 1'b0;
  bit           rx_steady     = 1'b0;
  bit           hold_off_req  = 1'b0;

  sliding_window_rate_limited_fifo_unit uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .cmd_i               (cmd_i),
    .arrival_time_i      (arrival_time_i),
    .packet_size_i       (packet_size_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .out_time_o          (out_time_o),
    .out_size_o          (out_size_o),
    .bytes_in_use_o      (bytes_in_use_o),
    .packets_in_use_o    (packets_in_use_o),
    .accepted_count_o    (accepted_count_o),
    .rate_reject_count_o (rate_reject_count_o),
    .full_reject_count_o (full_reject_count_o),
    .peak_bytes_o        (peak_bytes_o),
    .peak_packets_o      (peak_packets_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [31:0] bump_tally(input logic [31:0] v);
    return (v == swrl_pkg::TALLY_MAX) ? v : v + 32'd1;
  endfunction

  // Predict the result of one request and advance the predictor state
  task automatic gate_model_step(input swrl_pkg::cmd_e cmd, input logic [47:0] now,
                                 input logic [15:0] size, output bit produced,
                                 output gate_result_t r);
    int unsigned lim;
    int unsigned cap;
    int unsigned slot;
    logic [47:0] oldest;
    r = '0;
    produced = 1'b1;
    case (cmd)
      swrl_pkg::CMD_ARRIVE: begin
        lim = (cfg_rate < TRAIL_DEPTH) ? cfg_rate : TRAIL_DEPTH;
        cap = (cfg_buffer < GATE_DEPTH) ? cfg_buffer : GATE_DEPTH;
        // drop accept times that fell out of the window; later times never expire
        while (trail_fill > 0) begin
          oldest = accept_trail[trail_rd];
          if (now <= oldest || (now - oldest) <= {16'd0, cfg_window}) break;
          trail_rd = (trail_rd + 1) % TRAIL_DEPTH;
          trail_fill--;
        end
        if (trail_fill >= lim) begin
          rate_drops = bump_tally(rate_drops);
          r.status = swrl_pkg::ST_RATE_REJ;
        end else if (held_count >= cap) begin
          full_drops = bump_tally(full_drops);
          r.status = swrl_pkg::ST_FULL_REJ;
        end else begin
          slot = (held_head + held_count) % GATE_DEPTH;
          held_time[slot] = now;
          held_size[slot] = size;
          held_count++;
          accept_trail[(trail_rd + trail_fill) % TRAIL_DEPTH] = now;
          trail_fill++;
          bytes_held += size;
          if (bytes_held > swrl_pkg::BYTE_MAX) bytes_held = swrl_pkg::BYTE_MAX;
          if (bytes_held > byte_high) byte_high = bytes_held;
          if (held_count > pkt_high) pkt_high = held_count;
          accepts = bump_tally(accepts);
          r.status = swrl_pkg::ST_ACCEPTED;
        end
      end
      swrl_pkg::CMD_DEQUEUE: begin
        if (held_count == 0) begin
          r.status = swrl_pkg::ST_EMPTY;
        end else begin
          r.out_time = held_time[held_head];
          r.out_size = held_size[held_head];
          held_head = (held_head + 1) % GATE_DEPTH;
          held_count--;
          bytes_held = (bytes_held > r.out_size) ? bytes_held - r.out_size : 0;
          r.status = swrl_pkg::ST_DEQUEUED;
        end
      end
      swrl_pkg::CMD_CLEAR: begin
        // the packet occupancy peak survives a clear
        held_head = 0;
        held_count = 0;
        trail_rd = 0;
        trail_fill = 0;
        bytes_held = 0;
        byte_high = 0;
        accepts = '0;
        rate_drops = '0;
        full_drops = '0;
        r.status = swrl_pkg::ST_CLEARED;
      end
      default: produced = 1'b0;
    endcase
    r.bytes_in_use   = 22'(bytes_held);
    r.packets_in_use = 7'(held_count);
    r.accepted       = accepts;
    r.rate_rejects   = rate_drops;
    r.full_rejects   = full_drops;
    r.peak_bytes     = 22'(byte_high);
    r.peak_packets   = 7'(pkt_high);
  endtask

  // Offer one request, hold it until taken, predict, then idle for a random gap that may be zero
  task automatic send_request(input swrl_pkg::cmd_e cmd, input logic [47:0] t,
                              input logic [15:0] sz);
    bit produced;
    gate_result_t r;
    int unsigned gap;
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    arrival_time_i <= t;
    packet_size_i  <= sz;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gate_model_step(cmd, t, sz, produced, r);
    if (produced) gate_results_q.push_back(r);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait until the gate has delivered everything and finished any silent request
  task automatic settle();
    in_valid_i <= 1'b0;
    while (gate_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive cycles
  task automatic write_config(input logic [31:0] win, input logic [6:0] rate,
                              input logic [6:0] depth);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= swrl_pkg::CFG_WINDOW;
    cfg_data_i <= win;
    @(posedge clk_i);
    cfg_idx_i  <= swrl_pkg::CFG_RATE;
    cfg_data_i <= {25'd0, rate};
    @(posedge clk_i);
    cfg_idx_i  <= swrl_pkg::CFG_BUFFER;
    cfg_data_i <= {25'd0, depth};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_window = win;
    cfg_rate   = rate;
    cfg_buffer = depth;
  endtask

  // One random request: mostly arrivals with advancing time, plus dequeues, clears and noise
  task automatic send_random_request(inout logic [47:0] now_ms, input int unsigned span,
                                     output bit ignored);
    int unsigned pick;
    int unsigned sel;
    logic [47:0] t;
    logic [15:0] sz;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    t    = 48'({$urandom, $urandom});
    sz   = 16'($urandom);
    ignored = 1'b0;
    if (pick < 63) begin
      if (sel < 5) sz = 16'd0;
      else if (sel < 10) sz = 16'hFFFF;
      if (pick < 58) begin
        if (sel < 70) now_ms = now_ms + $urandom_range(0, span);
        else if (sel < 95) now_ms = now_ms + $urandom_range(span, 4 * span + 1);
        else now_ms = now_ms + 48'({$urandom, $urandom});
        t = now_ms;
      end else begin
        // time going backwards
        t = now_ms - $urandom_range(1, span + 1);
      end
      send_request(swrl_pkg::CMD_ARRIVE, t, sz);
    end else if (pick < 92) begin
      send_request(swrl_pkg::CMD_DEQUEUE, t, sz);
    end else if (pick < 96) begin
      send_request(swrl_pkg::CMD_CLEAR, t, sz);
    end else begin
      ignored = 1'b1;
      send_request(swrl_pkg::CMD_NONE, t, sz);
    end
  endtask

  // Field extremes, every command and the register corner cases
  task automatic test_directed_cases();
    send_request(swrl_pkg::CMD_DEQUEUE, 48'd0, 16'd0);
    send_request(swrl_pkg::CMD_NONE, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    send_request(swrl_pkg::CMD_ARRIVE, 48'd0, 16'd0);
    send_request(swrl_pkg::CMD_ARRIVE, 48'd5, 16'hFFFF);
    send_request(swrl_pkg::CMD_DEQUEUE, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    send_request(swrl_pkg::CMD_CLEAR, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    // zero window, two per window, single packet buffer
    settle();
    write_config(32'd0, 7'd2, 7'd1);
    send_request(swrl_pkg::CMD_ARRIVE, 48'd100, 16'd7);
    send_request(swrl_pkg::CMD_ARRIVE, 48'd100, 16'd9);
    send_request(swrl_pkg::CMD_DEQUEUE, 48'd0, 16'd0);
    send_request(swrl_pkg::CMD_ARRIVE, 48'd100, 16'd11);
    send_request(swrl_pkg::CMD_ARRIVE, 48'd100, 16'd13);
    send_request(swrl_pkg::CMD_ARRIVE, 48'd60, 16'd15);
    send_request(swrl_pkg::CMD_ARRIVE, 48'hFFFF_FFFF_FFFF, 16'd17);
    // rate limit zero
    settle();
    write_config(32'hFFFF_FFFF, 7'd0, 7'd64);
    send_request(swrl_pkg::CMD_ARRIVE, 48'd200, 16'd19);
    // buffer limit zero with an oversized rate limit
    settle();
    write_config(32'd1000, 7'd127, 7'd0);
    send_request(swrl_pkg::CMD_ARRIVE, 48'd300, 16'd21);
    send_request(swrl_pkg::CMD_DEQUEUE, 48'd0, 16'd0);
  endtask

  // Fill the time log and the FIFO to their depth with oversized limits
  task automatic test_depth_limits();
    settle();
    write_config(32'hFFFF_FFFF, 7'd127, 7'd127);
    send_request(swrl_pkg::CMD_CLEAR, 48'd0, 16'd0);
    for (int i = 0; i < 64; i++) begin
      send_request(swrl_pkg::CMD_ARRIVE, 48'd1000 + i, 16'hFFFF);
    end
    send_request(swrl_pkg::CMD_ARRIVE, 48'd2000, 16'd1234);
    for (int i = 0; i < 65; i++) send_request(swrl_pkg::CMD_DEQUEUE, 48'd0, 16'd0);
    // zero window keeps the log short, so the FIFO depth decides
    settle();
    write_config(32'd0, 7'd127, 7'd100);
    for (int i = 0; i < 66; i++) begin
      send_request(swrl_pkg::CMD_ARRIVE, 48'd5000 + i, 16'($urandom));
    end
    send_request(swrl_pkg::CMD_CLEAR, 48'd0, 16'd0);
  endtask

  // Several random settings, one of them without any idling
  task automatic test_random_traffic();
    logic [47:0] now_ms;
    logic [31:0] win;
    logic [6:0]  rate;
    logic [6:0]  depth;
    int unsigned span;
    int unsigned n;
    int unsigned r;
    bit ignored;
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      r = $urandom_range(0, 99);
      win = (r < 20) ? 32'd0 : (r < 30) ? 32'hFFFF_FFFF : $urandom_range(1, 200);
      r = $urandom_range(0, 99);
      rate = (r < 10) ? 7'd0 : (r < 20) ? 7'd64 : (r < 30) ? 7'($urandom_range(65, 127)) :
             7'($urandom_range(1, 40));
      r = $urandom_range(0, 99);
      depth = (r < 10) ? 7'd0 : (r < 20) ? 7'd64 : (r < 30) ? 7'($urandom_range(65, 127)) :
              7'($urandom_range(1, 40));
      write_config(win, rate, depth);
      tx_steady = (ph == 2);
      rx_steady = (ph == 2);
      now_ms = 48'({$urandom, $urandom});
      span = (win > 32'd400) ? 50 : win / 2 + 1;
      n = 0;
      while (n < 50) begin
        send_random_request(now_ms, span, ignored);
        if (!ignored) n++;
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Hold off the result side while requests keep coming
  task automatic test_result_backpressure();
    logic [47:0] now_ms;
    int unsigned n;
    bit ignored;
    settle();
    write_config(32'd5, 7'd64, 7'd64);
    now_ms = 48'({$urandom, $urandom});
    tx_steady = 1'b1;
    hold_off_req = 1'b1;
    n = 0;
    while (n < 100) begin
      send_random_request(now_ms, 3, ignored);
      if (!ignored) n++;
    end
    tx_steady = 1'b0;
  endtask

  // Result side ready pattern, with a long counted hold-off on request
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYC) @(posedge clk_i);
      end else if (rx_steady || $urandom_range(0, 99) < 60) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    gate_result_t want;
    gate_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, out_time_o, out_size_o, bytes_in_use_o, packets_in_use_o,
             accepted_count_o, rate_reject_count_o, full_reject_count_o,
             peak_bytes_o, peak_packets_o};
      if (gate_results_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("unexpected result: status %0d", status_o);
      end else begin
        want = gate_results_q.pop_front();
        if (got !== want) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display({"mismatch exp: st %0d t %h sz %h bytes %0d pkts %0d",
                      " acc %0d rr %0d fr %0d pb %0d pp %0d"},
                     want.status, want.out_time, want.out_size, want.bytes_in_use,
                     want.packets_in_use, want.accepted, want.rate_rejects,
                     want.full_rejects, want.peak_bytes, want.peak_packets);
            $display({"         got: st %0d t %h sz %h bytes %0d pkts %0d",
                      " acc %0d rr %0d fr %0d pb %0d pp %0d"},
                     got.status, got.out_time, got.out_size, got.bytes_in_use,
                     got.packets_in_use, got.accepted, got.rate_rejects,
                     got.full_rejects, got.peak_bytes, got.peak_packets);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sliding_window_rate_limited_fifo_unit NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_depth_limits();
    test_random_traffic();
    test_result_backpressure();
    // drain the result side, then allow for trailing output
    in_valid_i <= 1'b0;
    while (gate_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (bad_results == 0 && gate_results_q.size() == 0) begin
      $display("tb_sliding_window_rate_limited_fifo_unit OK");
    end else begin
      $display("tb_sliding_window_rate_limited_fifo_unit NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/swrl_pkg.sv
rtl/swrl_ram.sv
rtl/sliding_window_rate_limited_fifo_unit.sv
sim/tb_sliding_window_rate_limited_fifo_unit.sv
